// File: src/vsl_pkg.sv
// Shared types and constants for the vector set-length block.
// No dependencies; every other file except vsl_mul uses this package.
package vsl_pkg;

  // Word field widths, fixed by the channel format
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned LEN_W    = 15;
  localparam int unsigned MODE_W   = 2;

  // Derived arithmetic widths
  localparam int unsigned LENSQ_W  = 2 * LEN_W;    // len^2 and post-halving norm^2
  localparam int unsigned ROOT_W   = LEN_W;        // integer square root result
  localparam int unsigned DVD_W    = 2 * LENSQ_W;  // widest dividend (a^2 * len^2)

  // Iteration counts of the shared divide / root unit
  localparam int unsigned EUC_QBITS  = LENSQ_W;
  localparam int unsigned MAX_QBITS  = LEN_W;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned ITR_CNT_W  = 5;

  // Pre-halving bound on the sum of magnitudes
  localparam int unsigned HALVE_LIMIT = 30000;

  // scale_mode codes
  localparam logic [MODE_W-1:0] MODE_TRUNC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CEIL     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAXN     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_TRUNC;
  localparam int unsigned       MODE_MAXN_BIT = 1;

  typedef enum logic [1:0] {
    ITR_DIV_EUC = 2'd0,
    ITR_DIV_MAX = 2'd1,
    ITR_SQRT    = 2'd2
  } itr_op_e;

  typedef struct packed {
    logic    start;
    itr_op_e op;
  } itr_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic exact;
  } itr_rsp_t;

endpackage

// File: src/vsl_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on vsl_pkg for field widths.
interface vsl_in_if;
  import vsl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] x_in;
  logic signed [FIELD_W-1:0] y_in;
  logic signed [FIELD_W-1:0] z_in;
  logic        [LEN_W-1:0]   target_length;

  modport source (output valid, x_in, y_in, z_in, target_length, input ready);
  modport sink   (input valid, x_in, y_in, z_in, target_length, output ready);
endinterface

interface vsl_out_if;
  import vsl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] x_out;
  logic signed [FIELD_W-1:0] y_out;
  logic signed [FIELD_W-1:0] z_out;
  logic                      zero_error;

  modport source (output valid, x_out, y_out, z_out, zero_error, input ready);
  modport sink   (input valid, x_out, y_out, z_out, zero_error, output ready);
endinterface

// File: src/vsl_mul.sv
// Shared unsigned multiplier with a registered product.
// No package dependency.
module vsl_mul #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  logic [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*W)'(a_i) * (2*W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: src/vsl_itr.sv
// Iterative restoring divider and digit-by-digit square root, one bit per cycle,
// sharing one compare/subtract path. Depends on vsl_pkg.
module vsl_itr #(
  parameter int unsigned DVS_W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vsl_pkg::itr_req_t            req_i,
  input  logic [vsl_pkg::DVD_W-1:0]    dividend_i,
  input  logic [DVS_W-1:0]             divisor_i,
  output vsl_pkg::itr_rsp_t            rsp_o,
  output logic [vsl_pkg::EUC_QBITS-1:0] quo_o
);
  import vsl_pkg::*;

  localparam int unsigned REM_W = DVS_W + 1;

  logic                 busy_q, done_q;
  logic [ITR_CNT_W-1:0] cnt_q;
  itr_op_e              op_q;
  logic [REM_W-1:0]     rem_q;
  logic [DVD_W-1:0]     dvd_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [EUC_QBITS-1:0] quo_q;

  logic [REM_W-1:0]     lhs, rhs;
  logic [REM_W:0]       diff;
  logic                 ge;
  logic                 start;
  logic [REM_W-1:0]     rem_init;
  logic [DVD_W-1:0]     dvd_init;
  logic [ITR_CNT_W-1:0] cnt_init;

  assign start = req_i.start && !busy_q;

  // shared trial subtract: divisor for divide, {root, 01} for root
  always_comb begin
    if (op_q == ITR_SQRT) begin
      lhs = {rem_q[REM_W-3:0], dvd_q[DVD_W-1 -: 2]};
      rhs = REM_W'({quo_q[ROOT_W-1:0], 2'b01});
    end else begin
      lhs = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
      rhs = REM_W'(dvs_q);
    end
    diff = {1'b0, lhs} - {1'b0, rhs};
    ge   = ~diff[REM_W];
  end

  // preload: for the divides the high part of the dividend seeds the remainder; the root starts from zero
  always_comb begin
    unique case (req_i.op)
      ITR_DIV_EUC: begin
        rem_init = REM_W'(dividend_i >> EUC_QBITS);
        dvd_init = dividend_i << (DVD_W - EUC_QBITS);
        cnt_init = ITR_CNT_W'(EUC_QBITS);
      end
      ITR_DIV_MAX: begin
        rem_init = REM_W'(dividend_i >> MAX_QBITS);
        dvd_init = dividend_i << (DVD_W - MAX_QBITS);
        cnt_init = ITR_CNT_W'(MAX_QBITS);
      end
      default: begin
        rem_init = '0;
        dvd_init = dividend_i << (DVD_W - LENSQ_W);
        cnt_init = ITR_CNT_W'(SQRT_STEPS);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ITR_DIV_EUC;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= cnt_init;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ITR_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      rem_q <= rem_init;
      dvd_q <= dvd_init;
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[REM_W-1:0] : lhs;
      quo_q <= {quo_q[EUC_QBITS-2:0], ge};
      dvd_q <= (op_q == ITR_SQRT) ? (dvd_q << 2) : (dvd_q << 1);
    end
  end

  assign rsp_o = '{busy: busy_q, done: done_q, exact: (rem_q == '0)};
  assign quo_o = quo_q;

endmodule

// File: src/vector_set_length_top.sv
// Paths from accept to result valid: an exact-length vector passes through unchanged;
// Euclidean scaling first runs h halving passes (0..18 at 32-bit components); a zero
// vector is flagged after halving; max-norm mode ends early when len or the vector is zero.
// One word at a time: the next input is taken only once the result is registered.
// Cost is set by the shared divider/root unit: per component a 30-step divide plus a
// 15-step root (Euclidean) or a 15-step divide (max-norm). Reset clears control and mode.
module vector_set_length_top #(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vsl_pkg::MODE_W-1:0]   cfg_wdata_i,
  vsl_in_if.sink                       in_i,
  vsl_out_if.source                    out_o
);
  import vsl_pkg::*;

  // Magnitude of the most negative component needs the full component width.
  localparam int unsigned MW    = COMPONENT_WIDTH;
  // Multiplier also forms a^2 * len^2 (30 x 30 bits) after halving.
  localparam int unsigned MUL_W = (MW > LENSQ_W) ? MW : LENSQ_W;
  localparam int unsigned S_W   = 2 * MW + 2;   // sum of three squares
  localparam int unsigned SUM_W = MW + 2;       // sum of three magnitudes
  localparam int unsigned Q_W   = ROOT_W + 1;   // root plus ceiling increment
  localparam int unsigned N_COMP = 3;
  localparam logic [1:0]  COMP_LAST = 2'(N_COMP - 1);
  localparam logic [2:0]  CNT_LAST  = 3'(N_COMP + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SQ0   = 11'b00000000010,  // exact squared norm vs len^2
    S_HALVE = 11'b00000000100,
    S_SQ1   = 11'b00000001000,  // squared norm after halving
    S_NUM   = 11'b00000010000,  // a^2 * len^2 for one component
    S_DIV   = 11'b00000100000,
    S_SQRT  = 11'b00001000000,
    S_MAX   = 11'b00010000000,
    S_MNUM  = 11'b00100000000,  // |c| * len
    S_MDIV  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  // ---------------------------------------------------------------- control state
  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic [2:0]          cnt_q, cnt_d;
  logic [1:0]          comp_q, comp_d;
  logic                out_valid_q, out_valid_d;

  // ---------------------------------------------------------------- working word
  logic [MW-1:0]       a_q [N_COMP];
  logic [MW-1:0]       a_d [N_COMP];
  logic                neg_q [N_COMP];
  logic                neg_d [N_COMP];
  logic [FIELD_W-1:0]  r_q [N_COMP];
  logic [FIELD_W-1:0]  r_d [N_COMP];
  logic                err_q, err_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [LENSQ_W-1:0]  lensq_q, lensq_d;
  logic [S_W-1:0]      s_q, s_d;
  logic [MW-1:0]       mx_q, mx_d;
  logic                dexact_q, dexact_d;

  // ---------------------------------------------------------------- result register
  logic [FIELD_W-1:0]  ox_q, oy_q, oz_q;
  logic                oerr_q;
  logic                out_load;

  // ---------------------------------------------------------------- shared units
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  mul_p;
  itr_req_t            itr_req;
  itr_rsp_t            itr_rsp;
  logic [DVD_W-1:0]    itr_dvd;
  logic [MUL_W-1:0]    itr_dvs;
  logic [EUC_QBITS-1:0] itr_quo;

  vsl_mul #(.W(MUL_W)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  vsl_itr #(.DVS_W(MUL_W)) u_itr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (itr_req),
    .dividend_i (itr_dvd),
    .divisor_i  (itr_dvs),
    .rsp_o      (itr_rsp),
    .quo_o      (itr_quo)
  );

  // ---------------------------------------------------------------- input decode
  // Only the low COMPONENT_WIDTH bits of each field carry the component.
  logic [FIELD_W-1:0] in_w    [N_COMP];
  logic [MW-1:0]      in_v    [N_COMP];
  logic [MW-1:0]      in_mag  [N_COMP];
  logic               in_neg  [N_COMP];
  logic [FIELD_W-1:0] in_sext [N_COMP];
  logic               in_acc;

  assign in_w[0] = in_i.x_in;
  assign in_w[1] = in_i.y_in;
  assign in_w[2] = in_i.z_in;

  always_comb begin
    for (int i = 0; i < N_COMP; i++) begin
      in_v[i]    = in_w[i][MW-1:0];
      in_neg[i]  = in_v[i][MW-1];
      in_mag[i]  = in_neg[i] ? (MW'(0) - in_v[i]) : in_v[i];
      in_sext[i] = FIELD_W'($signed(in_v[i]));
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------- per-step muxes
  logic [MW-1:0]      a_cnt, a_comp;
  logic               neg_comp;
  logic [SUM_W-1:0]   mag_sum;
  logic               over_limit;
  logic [MW-1:0]      mx01, mx_all;
  logic               ceil_inc;
  logic [Q_W-1:0]     q_euc, q_max;
  logic [FIELD_W-1:0] res_euc, res_max;

  always_comb begin
    unique case (cnt_q)
      3'd0:    a_cnt = a_q[0];
      3'd1:    a_cnt = a_q[1];
      3'd2:    a_cnt = a_q[2];
      default: a_cnt = '0;
    endcase
    unique case (comp_q)
      2'd0: begin
        a_comp   = a_q[0];
        neg_comp = neg_q[0];
      end
      2'd1: begin
        a_comp   = a_q[1];
        neg_comp = neg_q[1];
      end
      default: begin
        a_comp   = a_q[2];
        neg_comp = neg_q[2];
      end
    endcase
  end

  // halving pass test: |x|+|y|+|z| against the limit
  assign mag_sum    = SUM_W'(a_q[0]) + SUM_W'(a_q[1]) + SUM_W'(a_q[2]);
  assign over_limit = mag_sum > SUM_W'(HALVE_LIMIT);

  assign mx01   = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
  assign mx_all = (mx01 > a_q[2]) ? mx01 : a_q[2];

  // Ceiling mode rounds a positive result up unless a^2*len^2/S is an exact square:
  // the divide must leave no remainder and the root must leave no remainder.
  assign ceil_inc = (mode_q == MODE_CEIL) && !neg_comp && !(dexact_q && itr_rsp.exact);
  assign q_euc    = Q_W'(itr_quo[ROOT_W-1:0]) + Q_W'(ceil_inc);
  assign q_max    = Q_W'(itr_quo[MAX_QBITS-1:0]);
  assign res_euc  = neg_comp ? (FIELD_W'(0) - FIELD_W'(q_euc)) : FIELD_W'(q_euc);
  assign res_max  = neg_comp ? (FIELD_W'(0) - FIELD_W'(q_max)) : FIELD_W'(q_max);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    comp_d   = comp_q;
    a_d      = a_q;
    neg_d    = neg_q;
    r_d      = r_q;
    err_d    = err_q;
    len_d    = len_q;
    lensq_d  = lensq_q;
    s_d      = s_q;
    mx_d     = mx_q;
    dexact_d = dexact_q;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    itr_req  = '{start: 1'b0, op: ITR_DIV_EUC};
    itr_dvd  = '0;
    itr_dvs  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < N_COMP; i++) begin
            a_d[i]   = in_mag[i];
            neg_d[i] = in_neg[i];
            r_d[i]   = in_sext[i];
          end
          len_d   = in_i.target_length;
          err_d   = 1'b0;
          s_d     = '0;
          cnt_d   = '0;
          state_d = mode_q[MODE_MAXN_BIT] ? S_MAX : S_SQ0;
        end
      end

      // Squares issue at count 0..2 and land in the next cycle from the multiplier register; len^2 issues at 3.
      S_SQ0, S_SQ1: begin
        if (cnt_q < 3'(N_COMP)) begin
          mul_a = MUL_W'(a_cnt);
          mul_b = MUL_W'(a_cnt);
        end else begin
          mul_a = MUL_W'(len_q);
          mul_b = MUL_W'(len_q);
        end
        if (cnt_q != 3'd0 && cnt_q != CNT_LAST) begin
          s_d = s_q + S_W'(mul_p[2*MW-1:0]);
        end
        if (cnt_q == CNT_LAST) begin
          cnt_d = '0;
          if (state_q == S_SQ0) begin
            lensq_d = mul_p[LENSQ_W-1:0];
            // already at the requested length: pass through unchanged
            state_d = (s_q == S_W'(mul_p[LENSQ_W-1:0])) ? S_DONE : S_HALVE;
          end else if (s_q == '0) begin
            err_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            comp_d  = '0;
            state_d = S_NUM;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      S_HALVE: begin
        if (over_limit) begin
          for (int i = 0; i < N_COMP; i++) begin
            a_d[i] = a_q[i] >> 1;
          end
        end else begin
          s_d     = '0;
          cnt_d   = '0;
          state_d = S_SQ1;
        end
      end

      // a^2, then a^2 * len^2, then divide by the squared norm
      S_NUM: begin
        if (cnt_q == 3'd0) begin
          mul_a = MUL_W'(a_comp);
          mul_b = MUL_W'(a_comp);
          cnt_d = 3'd1;
        end else if (cnt_q == 3'd1) begin
          mul_a = MUL_W'(mul_p[LENSQ_W-1:0]);
          mul_b = MUL_W'(lensq_q);
          cnt_d = 3'd2;
        end else begin
          itr_req = '{start: 1'b1, op: ITR_DIV_EUC};
          itr_dvd = mul_p[DVD_W-1:0];
          itr_dvs = MUL_W'(s_q[LENSQ_W-1:0]);
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        if (itr_rsp.done) begin
          dexact_d = itr_rsp.exact;
          itr_req  = '{start: 1'b1, op: ITR_SQRT};
          itr_dvd  = DVD_W'(itr_quo);
          state_d  = S_SQRT;
        end
      end

      S_SQRT: begin
        if (itr_rsp.done) begin
          unique case (comp_q)
            2'd0:    r_d[0] = res_euc;
            2'd1:    r_d[1] = res_euc;
            default: r_d[2] = res_euc;
          endcase
          if (comp_q == COMP_LAST) begin
            state_d = S_DONE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = S_NUM;
          end
        end
      end

      S_MAX: begin
        if (len_q == '0) begin
          for (int i = 0; i < N_COMP; i++) begin
            r_d[i] = '0;
          end
          state_d = S_DONE;
        end else if (mx_all == '0) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          mx_d    = mx_all;
          comp_d  = '0;
          cnt_d   = '0;
          state_d = S_MNUM;
        end
      end

      S_MNUM: begin
        if (cnt_q == 3'd0) begin
          mul_a = MUL_W'(a_comp);
          mul_b = MUL_W'(len_q);
          cnt_d = 3'd1;
        end else begin
          itr_req = '{start: 1'b1, op: ITR_DIV_MAX};
          itr_dvd = mul_p[DVD_W-1:0];
          itr_dvs = MUL_W'(mx_q);
          cnt_d   = '0;
          state_d = S_MDIV;
        end
      end

      S_MDIV: begin
        if (itr_rsp.done) begin
          unique case (comp_q)
            2'd0:    r_d[0] = res_max;
            2'd1:    r_d[1] = res_max;
            default: r_d[2] = res_max;
          endcase
          if (comp_q == COMP_LAST) begin
            state_d = S_DONE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = S_MNUM;
          end
        end
      end

      // wait for the result register to free up
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    neg_q    <= neg_d;
    r_q      <= r_d;
    err_q    <= err_d;
    len_q    <= len_d;
    lensq_q  <= lensq_d;
    s_q      <= s_d;
    mx_q     <= mx_d;
    dexact_q <= dexact_d;
    if (out_load) begin
      ox_q   <= r_q[0];
      oy_q   <= r_q[1];
      oz_q   <= r_q[2];
      oerr_q <= err_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.x_out      = ox_q;
  assign out_o.y_out      = oy_q;
  assign out_o.z_out      = oz_q;
  assign out_o.zero_error = oerr_q;

  // ---------------------------------------------------------------- assertions
  ap_itr_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    itr_req.start |-> !itr_rsp.busy)
    else $error("divide/root unit started while busy");

  ap_itr_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    itr_rsp.done |-> (state_q == S_DIV || state_q == S_SQRT || state_q == S_MDIV))
    else $error("divide/root result arrived outside a wait state");

  ap_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word raised without a finished computation");

  ap_accept_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SQ0 || state_q == S_MAX))
    else $error("accepted word did not start a norm pass");

endmodule
